[src/bcmu_pkg.sv]
// ----------------------------------------------------------------------------
// bcmu_pkg
// Shared types and constants for the basic computer microoperation unit.
// ----------------------------------------------------------------------------
package bcmu_pkg;

    localparam int MODE_WIDTH = 5;
    localparam int PC_WIDTH   = 12;
    localparam int SC_WIDTH   = 4;

    typedef enum logic [MODE_WIDTH-1:0] {
        PCTOAR  = 5'd0,
        INCPC   = 5'd1,
        MARTOIR = 5'd2,
        IRTOAR  = 5'd3,
        IRTOI   = 5'd4,
        MARTOAR = 5'd5,
        CMA     = 5'd6,
        CLA     = 5'd7,
        CLE     = 5'd8,
        CME     = 5'd9,
        CIR     = 5'd10,
        CIL     = 5'd11,
        INCAC   = 5'd12,
        SPA     = 5'd13,
        SNA     = 5'd14,
        SZA     = 5'd15,
        SZE     = 5'd16,
        INCSC   = 5'd17,
        CLSC    = 5'd18,
        AND_OP  = 5'd19,
        ADD_OP  = 5'd20,
        LDA     = 5'd21,
        STA     = 5'd22,
        MARTOPC = 5'd23,
        BSA     = 5'd24,
        INCMAR  = 5'd25,
        MEMLOAD = 5'd26,
        NOP     = 5'd27
    } mode_t;

endpackage

[src/basic_computer_microop_unit.sv]
// ----------------------------------------------------------------------------
// basic_computer_microop_unit
// Executes one register-transfer microoperation per input transaction.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the input is taken
// throughput: one microoperation per cycle unless the output stalls; the memory
//   read for a new AR issues with the step; its data goes to the following step
// reset: rst_n clears AC, E, PC, AR, IR, I, SC and the output valid;
//   main memory is not cleared; MEM_DEPTH must be a power of two (unchecked)
module basic_computer_microop_unit #(
    parameter int MEM_DEPTH  = 4096,
    parameter int DATA_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // load_address, load_data, zero pad
    input  logic [((bcmu_pkg::PC_WIDTH+DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [bcmu_pkg::MODE_WIDTH-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // acc_value, extend_bit, prog_counter, addr_reg, instr_reg, indirect_bit,
    // seq_count, mem_at_addr, zero pad
    output logic [((3*DATA_WIDTH+2*bcmu_pkg::PC_WIDTH+bcmu_pkg::SC_WIDTH+2+7)/8)*8-1:0]
        m_axis_tdata
);

    localparam int AW     = $clog2(MEM_DEPTH);
    localparam int PW     = bcmu_pkg::PC_WIDTH;
    localparam int SW     = bcmu_pkg::SC_WIDTH;
    localparam int OUT_BITS = 3 * DATA_WIDTH + 2 * PW + SW + 2;
    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8;

    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                  ext_reg, ext_next;
    logic [PW-1:0]         pc_reg, pc_next;
    logic [PW-1:0]         ar_reg, ar_next;
    logic [DATA_WIDTH-1:0] ir_reg, ir_next;
    logic                  ind_reg, ind_next;
    logic [SW-1:0]         sc_reg, sc_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  rd_pend_reg;
    logic                  out_valid_reg;

    logic                  accept;
    logic                  ar_changed;
    logic [DATA_WIDTH-1:0] word_now;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]         load_address;
    logic [DATA_WIDTH-1:0] load_data;
    logic [PW-1:0]         pc_inc;
    logic [DATA_WIDTH+PW-1:0] pc_ext;
    logic [DATA_WIDTH+PW-1:0] word_ext;
    logic [DATA_WIDTH+PW-1:0] ir_ext;
    bcmu_pkg::mode_t       mode;

    // addresses wrap at the memory depth
    function automatic logic [AW-1:0] mem_idx(input logic [PW-1:0] addr);
        logic [AW+PW-1:0] wide;
        wide = {{AW{1'b0}}, addr};
        return wide[AW-1:0];
    endfunction

    assign mode         = bcmu_pkg::mode_t'(s_axis_tuser);
    assign load_address = s_axis_tdata[PW-1:0];
    assign load_data    = s_axis_tdata[PW+DATA_WIDTH-1:PW];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // word at AR: fresh read data after AR moved, else the tracked copy
    assign word_now = rd_pend_reg ? ram_rdata : word_reg;

    assign pc_inc   = pc_reg + {{(PW-1){1'b0}}, 1'b1};
    assign pc_ext   = {{DATA_WIDTH{1'b0}}, pc_reg};
    assign word_ext = {{PW{1'b0}}, word_now};
    assign ir_ext   = {{PW{1'b0}}, ir_reg};

    always_comb
    begin
        acc_next   = acc_reg;
        ext_next   = ext_reg;
        pc_next    = pc_reg;
        ar_next    = ar_reg;
        ir_next    = ir_reg;
        ind_next   = ind_reg;
        sc_next    = sc_reg;
        ar_changed = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = ar_reg;
        mem_wdata  = acc_reg;
        case (mode)
            bcmu_pkg::PCTOAR:
            begin
                ar_next    = pc_reg;
                ar_changed = 1'b1;
            end
            bcmu_pkg::INCPC:   pc_next = pc_inc;
            bcmu_pkg::MARTOIR: ir_next = word_now;
            bcmu_pkg::IRTOAR:
            begin
                ar_next    = ir_ext[PW-1:0];
                ar_changed = 1'b1;
            end
            bcmu_pkg::IRTOI:   ind_next = ir_reg[DATA_WIDTH-1];
            bcmu_pkg::MARTOAR:
            begin
                ar_next    = word_ext[PW-1:0];
                ar_changed = 1'b1;
            end
            bcmu_pkg::CMA:     acc_next = ~acc_reg;
            bcmu_pkg::CLA:     acc_next = '0;
            bcmu_pkg::CLE:     ext_next = 1'b0;
            bcmu_pkg::CME:     ext_next = ~ext_reg;
            bcmu_pkg::CIR:
            begin
                acc_next = {ext_reg, acc_reg[DATA_WIDTH-1:1]};
                ext_next = acc_reg[0];
            end
            bcmu_pkg::CIL:
            begin
                acc_next = {acc_reg[DATA_WIDTH-2:0], ext_reg};
                ext_next = acc_reg[DATA_WIDTH-1];
            end
            bcmu_pkg::INCAC:   acc_next = acc_reg + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
            bcmu_pkg::SPA:     pc_next = acc_reg[DATA_WIDTH-1] ? pc_reg : pc_inc;
            bcmu_pkg::SNA:     pc_next = acc_reg[DATA_WIDTH-1] ? pc_inc : pc_reg;
            bcmu_pkg::SZA:     pc_next = (acc_reg == '0) ? pc_inc : pc_reg;
            bcmu_pkg::SZE:     pc_next = ext_reg ? pc_reg : pc_inc;
            bcmu_pkg::INCSC:   sc_next = sc_reg + {{(SW-1){1'b0}}, 1'b1};
            bcmu_pkg::CLSC:    sc_next = '0;
            bcmu_pkg::AND_OP:  acc_next = acc_reg & word_now;
            bcmu_pkg::ADD_OP:  acc_next = acc_reg + word_now;
            bcmu_pkg::LDA:     acc_next = word_now;
            bcmu_pkg::STA:     mem_we = 1'b1;
            bcmu_pkg::MARTOPC: pc_next = word_ext[PW-1:0];
            bcmu_pkg::BSA:
            begin
                mem_we    = 1'b1;
                mem_wdata = pc_ext[DATA_WIDTH-1:0];
                pc_next   = ar_reg + {{(PW-1){1'b0}}, 1'b1};
            end
            bcmu_pkg::INCMAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = word_now + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
            end
            bcmu_pkg::MEMLOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = load_address;
                mem_wdata = load_data;
            end
            default:
            begin
            end
        endcase
    end

    // keep the copy of the word at AR current across writes to that entry
    always_comb
    begin
        if (mem_we && (mem_idx(mem_waddr) == mem_idx(ar_reg)))
        begin
            word_next = mem_wdata;
        end
        else
        begin
            word_next = word_now;
        end
    end

    bcmu_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && mem_we),
        .waddr (mem_idx(mem_waddr)),
        .wdata (mem_wdata),
        .re    (accept && ar_changed),
        .raddr (mem_idx(ar_next)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ext_reg       <= 1'b0;
            pc_reg        <= '0;
            ar_reg        <= '0;
            ir_reg        <= '0;
            ind_reg       <= 1'b0;
            sc_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                acc_reg     <= acc_next;
                ext_reg     <= ext_next;
                pc_reg      <= pc_next;
                ar_reg      <= ar_next;
                ir_reg      <= ir_next;
                ind_reg     <= ind_next;
                sc_reg      <= sc_next;
                rd_pend_reg <= ar_changed;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload copy, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    // the result shows the machine state, which holds until the next transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, word_now, sc_reg, ind_reg, ir_reg,
                            ar_reg, pc_reg, ext_reg, acc_reg};

endmodule

[src/bcmu_ram.sv]
// ----------------------------------------------------------------------------
// bcmu_ram
// Main memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bcmu_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bcmu_checker.sv]
// ----------------------------------------------------------------------------
// bcmu_checker
// Port-level checks for the basic computer microoperation unit.
// ----------------------------------------------------------------------------
module bcmu_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [bcmu_pkg::MODE_WIDTH-1:0] s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((3*DATA_WIDTH+2*bcmu_pkg::PC_WIDTH+bcmu_pkg::SC_WIDTH+2+7)/8)*8-1:0]
        m_axis_tdata
);

    localparam int SC_LO = 2 * DATA_WIDTH + 2 * bcmu_pkg::PC_WIDTH + 2;

    logic in_acc;
    logic [bcmu_pkg::SC_WIDTH-1:0] sc_out;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign sc_out = m_axis_tdata[SC_LO+bcmu_pkg::SC_WIDTH-1:SC_LO];

    // every accepted transaction produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("no result after accepted transaction");

    // input only stalls while a result is held back
    a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a pending result stays until taken
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped before transaction");

    // clear accumulator leaves zero in the result
    a_cla_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_axis_tuser == bcmu_pkg::CLA)) |=> (m_axis_tdata[DATA_WIDTH-1:0] == '0))
        else $error("accumulator not cleared");

    // sequence counter increments by one and wraps
    a_sc_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_axis_tuser == bcmu_pkg::INCSC))
        |=> (sc_out == $past(sc_out) + {{(bcmu_pkg::SC_WIDTH-1){1'b0}}, 1'b1}))
        else $error("sequence counter increment wrong");

endmodule

bind basic_computer_microop_unit bcmu_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_bcmu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/basic_computer_microop_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_computer_microop_unit_tb
// Streams microoperations into the unit and checks every result transaction
// against a machine state kept alongside: AC, E, PC, AR, IR, I, SC and the
// memory word at AR. A short directed run hits wraps, skips and narrow loads,
// then random traffic runs under several idle and stall patterns.
// ----------------------------------------------------------------------------
module basic_computer_microop_unit_tb;

    localparam int MODE_W = bcmu_pkg::MODE_WIDTH;
    localparam int DATA_W = 16;
    localparam int MEM_D  = 4096;
    localparam int S_W    = ((bcmu_pkg::PC_WIDTH + DATA_W + 7) / 8) * 8;
    localparam int M_W    = ((3 * DATA_W + 2 * bcmu_pkg::PC_WIDTH + bcmu_pkg::SC_WIDTH + 2 + 7)
                             / 8) * 8;
    localparam int GEN    = 0;   // state copy used while building stimulus
    localparam int CHK    = 1;   // state copy advanced on accepted transactions
    localparam int RANDOM_ITEMS = 1700;
    localparam logic [MODE_W-1:0] UNUSED_LOW  = 5'd28;
    localparam logic [MODE_W-1:0] UNUSED_HIGH = 5'd31;

    typedef struct {
        logic [MODE_W-1:0] code;
        logic [11:0]       laddr;
        logic [15:0]       ldata;
        bit                drain;
    } microop_req_t;

    typedef struct packed {
        logic [15:0] acc;
        logic        e;
        logic [11:0] pc;
        logic [11:0] ar;
        logic [15:0] ir;
        logic        i;
        logic [3:0]  sc;
        logic [15:0] mword;
    } machine_view_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [S_W-1:0]    s_axis_tdata = '0;
    logic [MODE_W-1:0] s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [M_W-1:0]    m_axis_tdata;

    // two copies of the machine: one for stimulus shaping, one for checking
    logic [15:0] acc_s [2];
    logic        e_s   [2];
    logic [11:0] pc_s  [2];
    logic [11:0] ar_s  [2];
    logic [15:0] ir_s  [2];
    logic        i_s   [2];
    logic [3:0]  sc_s  [2];
    logic [15:0] mem_s [2][MEM_D];
    bit          written [MEM_D];

    microop_req_t  microop_q[$];
    machine_view_t machine_view_q[$];
    int            ops_issued;
    int            views_checked;
    int            error_cnt;
    bit            code_seen [32];

    basic_computer_microop_unit #(
        .MEM_DEPTH (MEM_D),
        .DATA_WIDTH(DATA_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void run_microop(int k, logic [MODE_W-1:0] code,
                                        logic [11:0] laddr, logic [15:0] ldata);
        logic [15:0] mword;
        logic        carry;
        mword = mem_s[k][ar_s[k]];
        case (code)
            bcmu_pkg::PCTOAR:  ar_s[k] = pc_s[k];
            bcmu_pkg::INCPC:   pc_s[k] = pc_s[k] + 12'd1;
            bcmu_pkg::MARTOIR: ir_s[k] = mword;
            bcmu_pkg::IRTOAR:  ar_s[k] = ir_s[k][11:0];
            bcmu_pkg::IRTOI:   i_s[k] = ir_s[k][15];
            bcmu_pkg::MARTOAR: ar_s[k] = mword[11:0];
            bcmu_pkg::CMA:     acc_s[k] = ~acc_s[k];
            bcmu_pkg::CLA:     acc_s[k] = '0;
            bcmu_pkg::CLE:     e_s[k] = 1'b0;
            bcmu_pkg::CME:     e_s[k] = ~e_s[k];
            bcmu_pkg::CIR:
            begin
                carry    = acc_s[k][0];
                acc_s[k] = {e_s[k], acc_s[k][15:1]};
                e_s[k]   = carry;
            end
            bcmu_pkg::CIL:
            begin
                carry    = acc_s[k][15];
                acc_s[k] = {acc_s[k][14:0], e_s[k]};
                e_s[k]   = carry;
            end
            bcmu_pkg::INCAC:   acc_s[k] = acc_s[k] + 16'd1;
            bcmu_pkg::SPA:     if (!acc_s[k][15]) pc_s[k] = pc_s[k] + 12'd1;
            bcmu_pkg::SNA:     if (acc_s[k][15]) pc_s[k] = pc_s[k] + 12'd1;
            bcmu_pkg::SZA:     if (acc_s[k] == '0) pc_s[k] = pc_s[k] + 12'd1;
            bcmu_pkg::SZE:     if (!e_s[k]) pc_s[k] = pc_s[k] + 12'd1;
            bcmu_pkg::INCSC:   sc_s[k] = sc_s[k] + 4'd1;
            bcmu_pkg::CLSC:    sc_s[k] = '0;
            bcmu_pkg::AND_OP:  acc_s[k] = acc_s[k] & mword;
            bcmu_pkg::ADD_OP:  acc_s[k] = acc_s[k] + mword;
            bcmu_pkg::LDA:     acc_s[k] = mword;
            bcmu_pkg::STA:     mem_s[k][ar_s[k]] = acc_s[k];
            bcmu_pkg::MARTOPC: pc_s[k] = mword[11:0];
            bcmu_pkg::BSA:
            begin
                mem_s[k][ar_s[k]] = {4'b0, pc_s[k]};
                pc_s[k] = ar_s[k] + 12'd1;
            end
            bcmu_pkg::INCMAR:  mem_s[k][ar_s[k]] = mword + 16'd1;
            bcmu_pkg::MEMLOAD: mem_s[k][laddr] = ldata;
            default: ;
        endcase
    endfunction

    function automatic void queue_item(logic [MODE_W-1:0] code, logic [11:0] laddr,
                                       logic [15:0] ldata, bit drain);
        microop_req_t req;
        req.code  = code;
        req.laddr = laddr;
        req.ldata = ldata;
        req.drain = drain;
        microop_q.push_back(req);
        if (code == bcmu_pkg::MEMLOAD)
            written[laddr] = 1'b1;
        run_microop(GEN, code, laddr, ldata);
    endfunction

    // any op that moves AR gets its target word loaded first, so no read
    // ever touches a word that was never written
    function automatic void queue_op(logic [MODE_W-1:0] code, bit drain);
        logic [11:0] ar_next;
        ar_next = ar_s[GEN];
        case (code)
            bcmu_pkg::PCTOAR:  ar_next = pc_s[GEN];
            bcmu_pkg::IRTOAR:  ar_next = ir_s[GEN][11:0];
            bcmu_pkg::MARTOAR: ar_next = mem_s[GEN][ar_s[GEN]][11:0];
            default: ;
        endcase
        if (!written[ar_next])
            queue_item(bcmu_pkg::MEMLOAD, ar_next, 16'($urandom), drain);
        queue_item(code, 12'($urandom), 16'($urandom), drain);
    endfunction

    function automatic int sender_idle_pct();
        case ((ops_issued / 150) % 4)
            0: return 0;
            1: return 52;
            2: return 0;
            default: return 7;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((ops_issued / 150) % 4)
            0: return 0;
            1: return 0;
            2: return 52;
            default: return 7;
        endcase
    endfunction

    function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            error_cnt++;
            if (error_cnt <= 10)
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         views_checked, fname, want, got);
        end
    endfunction

    // driver: one transaction per handshake, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        microop_req_t  req;
        machine_view_t view;
        bit            go;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = microop_q.pop_front();
                run_microop(CHK, req.code, req.laddr, req.ldata);
                view.acc   = acc_s[CHK];
                view.e     = e_s[CHK];
                view.pc    = pc_s[CHK];
                view.ar    = ar_s[CHK];
                view.ir    = ir_s[CHK];
                view.i     = i_s[CHK];
                view.sc    = sc_s[CHK];
                view.mword = mem_s[CHK][ar_s[CHK]];
                machine_view_q.push_back(view);
                code_seen[req.code] = 1'b1;
                ops_issued++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                go = 1'b0;
                if (microop_q.size() != 0)
                begin
                    if (microop_q[0].drain && machine_view_q.size() != 0)
                        go = 1'b0;
                    else
                        go = ($urandom_range(0, 99) >= sender_idle_pct());
                end
                s_axis_tvalid <= go;
                if (go)
                begin
                    s_axis_tdata <= {4'b0, microop_q[0].ldata, microop_q[0].laddr};
                    s_axis_tuser <= microop_q[0].code;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end

    // monitor: each result transaction against the oldest expectation
    always @(posedge clk)
    begin : monitor_proc
        machine_view_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (machine_view_q.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("result transaction with no expectation: %h", m_axis_tdata);
            end
            else
            begin
                want = machine_view_q.pop_front();
                check_field("acc_value", want.acc, m_axis_tdata[15:0]);
                check_field("extend_bit", 16'(want.e), 16'(m_axis_tdata[16]));
                check_field("prog_counter", 16'(want.pc), 16'(m_axis_tdata[28:17]));
                check_field("addr_reg", 16'(want.ar), 16'(m_axis_tdata[40:29]));
                check_field("instr_reg", want.ir, m_axis_tdata[56:41]);
                check_field("indirect_bit", 16'(want.i), 16'(m_axis_tdata[57]));
                check_field("seq_count", 16'(want.sc), 16'(m_axis_tdata[61:58]));
                check_field("mem_at_addr", want.mword, m_axis_tdata[77:62]);
                views_checked++;
            end
        end
    end

    initial
    begin : stimulus_proc
        logic [MODE_W-1:0] directed_ops[] = '{
            bcmu_pkg::MARTOPC, bcmu_pkg::INCPC, bcmu_pkg::MARTOAR, bcmu_pkg::LDA,
            bcmu_pkg::CIR, bcmu_pkg::CIL, bcmu_pkg::CME, bcmu_pkg::SZE, bcmu_pkg::SPA,
            bcmu_pkg::SNA, bcmu_pkg::CMA, bcmu_pkg::SPA, bcmu_pkg::CLA, bcmu_pkg::SZA,
            bcmu_pkg::CMA, bcmu_pkg::INCAC, bcmu_pkg::ADD_OP, bcmu_pkg::AND_OP,
            bcmu_pkg::STA, bcmu_pkg::INCMAR, bcmu_pkg::BSA, bcmu_pkg::MARTOIR,
            bcmu_pkg::IRTOI, bcmu_pkg::IRTOAR, bcmu_pkg::PCTOAR, bcmu_pkg::CLE,
            bcmu_pkg::SZE, bcmu_pkg::INCSC, bcmu_pkg::CLSC, bcmu_pkg::NOP,
            UNUSED_LOW, UNUSED_HIGH
        };
        logic [MODE_W-1:0] code;
        int                pick;
        int                k;
        int                n;
        int                n_codes;

        for (k = 0; k < 2; k++)
        begin
            acc_s[k] = '0;
            e_s[k]   = 1'b0;
            pc_s[k]  = '0;
            ar_s[k]  = '0;
            ir_s[k]  = '0;
            i_s[k]   = 1'b0;
            sc_s[k]  = '0;
        end

        // AR is 0 out of reset, so word 0 has to be written first
        queue_item(bcmu_pkg::MEMLOAD, 12'h000, 16'hFFFF, 1'b0);
        queue_item(bcmu_pkg::MEMLOAD, 12'hFFF, 16'h8001, 1'b0);
        foreach (directed_ops[i])
            queue_op(directed_ops[i], 1'b0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                queue_item(bcmu_pkg::MEMLOAD, 12'($urandom), 16'($urandom),
                           (n % 300) == 0);
            else if (pick < 18)
                queue_item(bcmu_pkg::MEMLOAD, ar_s[GEN], 16'($urandom), (n % 300) == 0);
            else
            begin
                code = MODE_W'($urandom_range(0, 31));
                // keep clears rare so the sequence counter gets to wrap
                if (code == bcmu_pkg::CLSC && $urandom_range(0, 7) != 0)
                    code = bcmu_pkg::INCSC;
                if (code == bcmu_pkg::MEMLOAD)
                    queue_item(bcmu_pkg::MEMLOAD, 12'($urandom), 16'($urandom),
                               (n % 300) == 0);
                else
                    queue_op(code, (n % 300) == 0);
            end
            n++;
        end

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (microop_q.size() != 0 || machine_view_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        n_codes = 0;
        foreach (code_seen[i])
            if (code_seen[i])
                n_codes++;
        $display("ran %0d microoperations over %0d of 32 mode codes, %0d results checked",
                 ops_issued, n_codes, views_checked);
        $display("idle and stall phases rotated every 150 transactions");
        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d transactions pending", microop_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[basic_computer_microop_unit.f]
src/bcmu_pkg.sv
src/bcmu_ram.sv
src/basic_computer_microop_unit.sv
src/bcmu_checker.sv
bench/basic_computer_microop_unit_tb.sv
